// File: hdl/polyline_arc_length_interpolator_top_assert.svh
// assertion macros shared by the interpolator rtl
`ifndef POLYLINE_ARC_LENGTH_INTERPOLATOR_TOP_ASSERT_SVH
`define POLYLINE_ARC_LENGTH_INTERPOLATOR_TOP_ASSERT_SVH

// condition holds on every clock edge out of reset
`define PLAI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define PLAI_ASSERT_SAME(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the trigger
`define PLAI_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/plai_pkg.sv
package plai_pkg;

	localparam int MAX_POINTS = 256;
	localparam int COORD_BITS = 32;
	localparam int ADDR_BITS  = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = ADDR_BITS + 1;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int ROOT_BITS  = PROD_BITS / 2;
	localparam int REM_BITS   = ROOT_BITS + 3;
	localparam int MAG_BITS   = COORD_BITS + 3;
	localparam int SUM_BITS   = COORD_BITS + 4;
	localparam int STEP_BITS  = $clog2(PROD_BITS);
	localparam int ENTRY_BITS = 4 * COORD_BITS;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} item_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_FULL = 2'd2,
		ST_ZSEG = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		DC_NONE, DC_CAPTURE, DC_CLEAR, DC_RD_PREV, DC_LATCH_P1,
		DC_MUL_START, DC_MUL_STEP, DC_SQRT_START, DC_SQRT_STEP, DC_STORE,
		DC_SCAN_START, DC_SCAN_RD, DC_SCAN_CHK, DC_RD_A, DC_RD_B,
		DC_LATCH_P2, DC_DIV_START, DC_DIV_STEP, DC_FINISH, DC_RESULT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_RD_PREV, S_LATCH_PREV, S_MUL_START, S_MUL,
		S_SQRT_START, S_SQRT, S_STORE, S_SCAN_START, S_SCAN_RD, S_SCAN_CHK,
		S_RD_A, S_RD_B, S_LATCH_B, S_DIV_START, S_DIV, S_FINISH, S_RESULT
	} state_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic signed [COORD_BITS-1:0] l;
	} entry_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] coord;
	} ctrl_t;

	typedef struct packed {
		item_op_t op;
		logic     full;
		logic     few;
		logic     use_given;
		logic     last;
		logic     scan_done;
		logic     dl_zero;
	} stat_t;

endpackage

// File: hdl/plai_ram.sv
module plai_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/plai_ctrl.sv
module plai_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output plai_pkg::ctrl_t cmd,
	input  plai_pkg::stat_t sts
);
	import plai_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] coord_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:       if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				unique case (sts.op) inside
					OP_ADD: begin
						if (sts.full)           state_d = S_RESULT;
						else if (sts.use_given) state_d = S_STORE;
						else                    state_d = S_RD_PREV;
					end
					OP_QUERY:       state_d = sts.few ? S_RESULT : S_SCAN_START;
					OP_CLEAR, OP_NOP: state_d = S_RESULT;
					default:        state_d = S_RESULT;
				endcase
			end
			S_RD_PREV:    state_d = S_LATCH_PREV;
			S_LATCH_PREV: state_d = S_MUL_START;
			S_MUL_START:  state_d = S_MUL;
			S_MUL: begin
				if (sts.last) begin
					if (sts.op == OP_ADD) state_d = (coord_q == 2'd2) ? S_SQRT_START : S_MUL_START;
					else                  state_d = S_DIV_START;
				end
			end
			S_SQRT_START: state_d = S_SQRT;
			S_SQRT:       if (sts.last) state_d = S_STORE;
			S_STORE:      state_d = S_RESULT;
			S_SCAN_START: state_d = S_SCAN_RD;
			S_SCAN_RD:    state_d = S_SCAN_CHK;
			S_SCAN_CHK:   state_d = sts.scan_done ? S_RD_A : S_SCAN_RD;
			S_RD_A:       state_d = S_RD_B;
			S_RD_B:       state_d = S_LATCH_B;
			S_LATCH_B:    state_d = sts.dl_zero ? S_RESULT : S_MUL_START;
			S_DIV_START:  state_d = S_DIV;
			S_DIV:        if (sts.last) state_d = S_FINISH;
			S_FINISH:     state_d = (coord_q == 2'd2) ? S_RESULT : S_MUL_START;
			S_RESULT:     if (out_free) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.coord = coord_q;
		cmd.op    = DC_NONE;
		unique case (state_q)
			S_IDLE:       cmd.op = in_valid ? DC_CAPTURE : DC_NONE;
			S_DISPATCH:   cmd.op = (sts.op == OP_CLEAR) ? DC_CLEAR : DC_NONE;
			S_RD_PREV:    cmd.op = DC_RD_PREV;
			S_LATCH_PREV: cmd.op = DC_LATCH_P1;
			S_MUL_START:  cmd.op = DC_MUL_START;
			S_MUL:        cmd.op = DC_MUL_STEP;
			S_SQRT_START: cmd.op = DC_SQRT_START;
			S_SQRT:       cmd.op = DC_SQRT_STEP;
			S_STORE:      cmd.op = DC_STORE;
			S_SCAN_START: cmd.op = DC_SCAN_START;
			S_SCAN_RD:    cmd.op = DC_SCAN_RD;
			S_SCAN_CHK:   cmd.op = DC_SCAN_CHK;
			S_RD_A:       cmd.op = DC_RD_A;
			S_RD_B:       cmd.op = DC_RD_B;
			S_LATCH_B:    cmd.op = DC_LATCH_P2;
			S_DIV_START:  cmd.op = DC_DIV_START;
			S_DIV:        cmd.op = DC_DIV_STEP;
			S_FINISH:     cmd.op = DC_FINISH;
			S_RESULT:     cmd.op = out_free ? DC_RESULT : DC_NONE;
			default:      cmd.op = DC_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			coord_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				coord_q <= 2'd0;
			end else if ((state_q == S_MUL && sts.last && sts.op == OP_ADD) ||
			             state_q == S_FINISH) begin
				coord_q <= coord_q + 2'd1;
			end
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/plai_dp.sv
`include "polyline_arc_length_interpolator_top_assert.svh"

module plai_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [1:0]                           op,
	input  logic signed [plai_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [plai_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [plai_pkg::COORD_BITS-1:0] point_z,
	input  logic signed [plai_pkg::COORD_BITS-1:0] length_value,
	input  plai_pkg::ctrl_t                      cmd,
	output plai_pkg::stat_t                      sts,
	output logic signed [plai_pkg::COORD_BITS-1:0] out_x,
	output logic signed [plai_pkg::COORD_BITS-1:0] out_y,
	output logic signed [plai_pkg::COORD_BITS-1:0] out_z,
	output logic [1:0]                           status,
	output logic [plai_pkg::CNT_BITS-1:0]        count_now
);
	import plai_pkg::*;

	localparam logic signed [SUM_BITS-1:0] CMAX = SUM_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);
	localparam logic signed [SUM_BITS-1:0] CMIN = -CMAX - SUM_BITS'(1);

	function automatic logic [DIFF_BITS-1:0] mag(input logic signed [DIFF_BITS-1:0] v);
		return v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick(input entry_t e, input logic [1:0] c);
		logic signed [COORD_BITS-1:0] r;
		case (c)
			2'd0:    r = e.x;
			2'd1:    r = e.y;
			default: r = e.z;
		endcase
		return r;
	endfunction

	item_op_t                  op_q;
	entry_t                    in_q, p1_q, p2_q, res_q;
	status_t                   res_st_q;
	logic [CNT_BITS-1:0]       count_q;
	logic [PROD_BITS-1:0]      acc_q, mcand_q, num_q;
	logic [DIFF_BITS-1:0]      mplier_q;
	logic [REM_BITS-1:0]       rem_q;
	logic [ROOT_BITS-1:0]      root_q;
	logic [STEP_BITS-1:0]      cnt_q;
	logic [ADDR_BITS-1:0]      idx_q, j_q;

	// memory port
	logic                      ram_we;
	logic [ADDR_BITS-1:0]      ram_raddr;
	logic [ENTRY_BITS-1:0]     ram_rdata;
	entry_t                    rd_e;
	entry_t                    wr_e;

	// arithmetic
	logic signed [COORD_BITS-1:0] p1c;
	logic signed [DIFF_BITS-1:0]  dpos, dq, dl;
	logic [DIFF_BITS-1:0]         dmag;
	logic                         neg;
	logic [REM_BITS-1:0]          sq_r2, sq_trial, dv_r2;
	logic [ROOT_BITS:0]           seg_len;
	logic signed [SUM_BITS-1:0]   room, len_sum, fin_r;
	logic signed [COORD_BITS-1:0] len_new;
	logic                         rnd, big, hit, scan_last;
	logic [MAG_BITS-1:0]          magc;
	logic signed [COORD_BITS-1:0] fin_c;
	logic [CNT_BITS-1:0]          count_m1;

	assign rd_e     = entry_t'(ram_rdata);
	assign count_m1 = count_q - CNT_BITS'(1);
	assign p1c      = pick(p1_q, cmd.coord);
	assign dpos     = (op_q == OP_ADD) ? DIFF_BITS'(pick(in_q, cmd.coord)) - DIFF_BITS'(p1c)
	                                   : DIFF_BITS'(pick(p2_q, cmd.coord)) - DIFF_BITS'(p1c);
	assign dq       = DIFF_BITS'(in_q.l) - DIFF_BITS'(p1_q.l);
	assign dl       = DIFF_BITS'(p2_q.l) - DIFF_BITS'(p1_q.l);
	assign dmag     = mag(dl);
	assign neg      = dpos[DIFF_BITS-1] ^ dq[DIFF_BITS-1] ^ dl[DIFF_BITS-1];

	// square root digit step
	assign sq_r2    = {rem_q[REM_BITS-3:0], num_q[PROD_BITS-1 -: 2]};
	assign sq_trial = REM_BITS'({root_q, 2'b01});
	// restoring division step
	assign dv_r2    = {rem_q[REM_BITS-2:0], num_q[PROD_BITS-1]};

	// computed length with saturation
	assign seg_len  = (ROOT_BITS + 1)'(root_q) +
	                  (ROOT_BITS + 1)'(rem_q > REM_BITS'(root_q));
	assign room     = CMAX - SUM_BITS'(p1_q.l);
	assign len_sum  = SUM_BITS'(p1_q.l) + SUM_BITS'(seg_len);
	always_comb begin
		if (!in_q.l[COORD_BITS-1])           len_new = in_q.l;
		else if (count_q == '0)              len_new = '0;
		else if (SUM_BITS'(seg_len) >= room) len_new = CMAX[COORD_BITS-1:0];
		else                                 len_new = len_sum[COORD_BITS-1:0];
	end
	assign wr_e = '{x: in_q.x, y: in_q.y, z: in_q.z, l: len_new};

	// rounding and clamping of one coordinate
	assign rnd   = {rem_q[REM_BITS-2:0], 1'b0} >= REM_BITS'(dmag);
	assign big   = |num_q[PROD_BITS-1:MAG_BITS-1];
	assign magc  = big ? (MAG_BITS'(1) << (MAG_BITS - 1))
	                   : {1'b0, num_q[MAG_BITS-2:0]} + MAG_BITS'(rnd);
	assign fin_r = neg ? SUM_BITS'(p1c) - SUM_BITS'(magc) : SUM_BITS'(p1c) + SUM_BITS'(magc);
	always_comb begin
		if (fin_r > CMAX)      fin_c = CMAX[COORD_BITS-1:0];
		else if (fin_r < CMIN) fin_c = CMIN[COORD_BITS-1:0];
		else                   fin_c = fin_r[COORD_BITS-1:0];
	end

	assign hit       = rd_e.l > in_q.l;
	assign scan_last = ({1'b0, idx_q} == count_m1);

	always_comb begin
		unique case (cmd.op)
			DC_RD_PREV: ram_raddr = count_m1[ADDR_BITS-1:0];
			DC_RD_A:    ram_raddr = j_q - ADDR_BITS'(1);
			DC_RD_B:    ram_raddr = j_q;
			default:    ram_raddr = idx_q;
		endcase
	end
	assign ram_we = (cmd.op == DC_STORE);

	assign sts.op        = op_q;
	assign sts.full      = (count_q >= CNT_BITS'(MAX_POINTS));
	assign sts.few       = (count_q < CNT_BITS'(2));
	assign sts.use_given = !in_q.l[COORD_BITS-1] || (count_q == '0);
	assign sts.last      = (cnt_q == '0);
	assign sts.scan_done = hit || scan_last;
	assign sts.dl_zero   = (rd_e.l == p1_q.l);

	plai_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_BITS-1:0]),
		.wdata (wr_e),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == DC_CLEAR) begin
			count_q <= '0;
		end else if (cmd.op == DC_STORE) begin
			count_q <= count_q + CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DC_CAPTURE: begin
				op_q  <= item_op_t'(op);
				in_q  <= '{x: point_x, y: point_y, z: point_z, l: length_value};
				res_q <= '0;
				if (op == OP_ADD && count_q >= CNT_BITS'(MAX_POINTS))  res_st_q <= ST_FULL;
				else if (op == OP_QUERY && count_q < CNT_BITS'(2))     res_st_q <= ST_FEW;
				else                                                   res_st_q <= ST_OK;
			end
			DC_LATCH_P1: p1_q <= rd_e;
			DC_MUL_START: begin
				mcand_q  <= PROD_BITS'(mag(dpos));
				mplier_q <= (op_q == OP_ADD) ? mag(dpos) : mag(dq);
				cnt_q    <= STEP_BITS'(DIFF_BITS - 1);
				if (op_q != OP_ADD || cmd.coord == 2'd0) acc_q <= '0;
			end
			DC_MUL_STEP: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q - STEP_BITS'(1);
			end
			DC_SQRT_START: begin
				num_q  <= acc_q;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= STEP_BITS'(ROOT_BITS - 1);
			end
			DC_SQRT_STEP: begin
				if (sq_r2 >= sq_trial) begin
					rem_q  <= sq_r2 - sq_trial;
					root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= sq_r2;
					root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
				end
				num_q <= num_q << 2;
				cnt_q <= cnt_q - STEP_BITS'(1);
			end
			DC_SCAN_START: idx_q <= '0;
			DC_SCAN_CHK: begin
				if (hit)            j_q <= (idx_q == '0) ? ADDR_BITS'(1) : idx_q;
				else if (scan_last) j_q <= count_m1[ADDR_BITS-1:0];
				else                idx_q <= idx_q + ADDR_BITS'(1);
			end
			DC_RD_B: p1_q <= rd_e;
			DC_LATCH_P2: begin
				p2_q <= rd_e;
				if (rd_e.l == p1_q.l) begin
					res_q    <= '{x: p1_q.x, y: p1_q.y, z: p1_q.z, l: '0};
					res_st_q <= ST_ZSEG;
				end
			end
			DC_DIV_START: begin
				num_q <= acc_q;
				rem_q <= '0;
				cnt_q <= STEP_BITS'(PROD_BITS - 1);
			end
			DC_DIV_STEP: begin
				if (dv_r2 >= REM_BITS'(dmag)) begin
					rem_q <= dv_r2 - REM_BITS'(dmag);
					num_q <= {num_q[PROD_BITS-2:0], 1'b1};
				end else begin
					rem_q <= dv_r2;
					num_q <= {num_q[PROD_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q - STEP_BITS'(1);
			end
			DC_FINISH: begin
				case (cmd.coord)
					2'd0:    res_q.x <= fin_c;
					2'd1:    res_q.y <= fin_c;
					default: res_q.z <= fin_c;
				endcase
			end
			DC_RESULT: begin
				out_x     <= res_q.x;
				out_y     <= res_q.y;
				out_z     <= res_q.z;
				status    <= res_st_q;
				count_now <= count_q;
			end
			default: ;
		endcase
	end

	`PLAI_ASSERT_ALWAYS(a_count_range, count_q <= CNT_BITS'(MAX_POINTS),
		"point count out of range")
	`PLAI_ASSERT_SAME(a_store_room, cmd.op == DC_STORE, count_q < CNT_BITS'(MAX_POINTS),
		"store into full table")
	`PLAI_ASSERT_NEXT(a_store_count, cmd.op == DC_STORE,
		count_q == $past(count_q) + CNT_BITS'(1), "count not advanced by store")
	`PLAI_ASSERT_SAME(a_seg_range, cmd.op == DC_RD_A, j_q != '0 && {1'b0, j_q} < count_q,
		"segment index outside table")

endmodule

// File: hdl/polyline_arc_length_interpolator_top.sv
// polyline arc-length interpolator: holds up to 256 points (x, y, z and a
// cumulative length, all signed q16.16) in one 256 x 128 bit single-port-write
// ram. op 0 clears the table, op 1 adds a point (a negative length asks the
// block to compute previous length plus euclidean distance, saturated), op 2
// returns the point at a given length, interpolated or extrapolated on the
// bracketing segment. every beat in gives exactly one beat out with status and
// the point count after the operation. one item is worked at a time: clear,
// no-op, an add into a full table and a query on fewer than two points go
// straight to the result; an add with given length stores the point, an add
// with computed length first runs three 33-step shift-add squares and a
// 33-step digit-by-digit square root, and a query scans the stored lengths,
// reading then checking each entry, before three rounds of a 33-step multiply
// and a 66-step restoring divide for x, y and z; a zero-length segment skips
// those rounds. a finished result sits in the output register while the next
// beat is taken in; a stalled result holds the block in its result state for
// as long as the stall lasts.
module polyline_arc_length_interpolator_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             op,
	input  logic signed [plai_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [plai_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [plai_pkg::COORD_BITS-1:0] point_z,
	input  logic signed [plai_pkg::COORD_BITS-1:0] length_value,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [plai_pkg::COORD_BITS-1:0] out_x,
	output logic signed [plai_pkg::COORD_BITS-1:0] out_y,
	output logic signed [plai_pkg::COORD_BITS-1:0] out_z,
	output logic [1:0]                             status,
	output logic [plai_pkg::CNT_BITS-1:0]          count_now
);
	import plai_pkg::*;

	// command from the sequencer, flags back from the datapath
	ctrl_t cmd;
	stat_t sts;

	plai_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// point store, arithmetic units and the output register
	plai_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.length_value (length_value),
		.cmd          (cmd),
		.sts          (sts),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.status       (status),
		.count_now    (count_now)
	);

endmodule
